// ===== rtl/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg
// Types, character codes and digit decoding shared by the ASCII integer
// parser modules.
// ----------------------------------------------------------------------------
package aip_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       token_start;
    } t_in;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } t_out;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_DIGIT
    } t_phase;

    typedef enum logic [1:0] {
        RC_DEC,
        RC_HEX,
        RC_OCT,
        RC_BIN
    } t_radix;

    typedef struct packed {
        t_phase      phase;
        t_radix      radix_code;
        logic [31:0] accumulator;
        logic        negative;
        logic        have_digit;
    } t_state;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // A character that is no digit in any radix decodes to this value.
    localparam logic [5:0] DIGIT_NONE = 6'd63;

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            d = c - CH_LC_A + 8'd10;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            d = c - CH_UC_A + 8'd10;
        end else begin
            d = {2'b00, DIGIT_NONE};
        end
        return d[5:0];
    endfunction

    function automatic logic [4:0] radix_value(input t_radix r);
        logic [4:0] v;
        unique case (r)
            RC_HEX:  v = 5'd16;
            RC_OCT:  v = 5'd8;
            RC_BIN:  v = 5'd2;
            default: v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ascii_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming ASCII to 32-bit integer converter with sign and radix prefix.
// ----------------------------------------------------------------------------
// A token's ending request is held in the input register, its result in the
// result register. Throughput: one character request per cycle unless the
// result register stalls; the parse step is a single shift-and-add between them.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to idle, where characters are ignored until a token start.
// ----------------------------------------------------------------------------
module ascii_integer_parser_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  aip_pkg::t_in   i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output aip_pkg::t_out  o_out_data,
    input  logic           i_out_stall
);
    import aip_pkg::*;

    // Input register: holds one character request until the parse step
    // can move it on.
    logic   r_in_valid;
    t_in    r_in;

    // Parse state carried from character to character of a token.
    t_state r_state;
    t_state n_state;

    // Result register toward the downstream side.
    logic   r_out_valid;
    t_out   r_out;

    logic   step_valid;
    t_out   step_res;
    logic   out_free;
    logic   advance;
    logic   in_take;

    // The result register can take a new value when it is empty or is being
    // drained this cycle. A character only advances then, since it may end
    // its token and produce a result.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    aip_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // The state register is the parser's state machine; it moves only when
    // a character is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.radix_code  <= RC_DEC;
            r_state.accumulator <= 32'd0;
            r_state.negative    <= 1'b0;
            r_state.have_digit  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // A character that produces no result still frees the result register
    // if its previous content was taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/aip_step.sv =====
// ----------------------------------------------------------------------------
// aip_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
module aip_step (
    input  aip_pkg::t_state i_state,
    input  aip_pkg::t_in    i_item,
    output aip_pkg::t_state o_state,
    output logic            o_res_valid,
    output aip_pkg::t_out   o_res
);
    import aip_pkg::*;

    t_state      s;
    logic        take;
    logic [5:0]  dv;
    logic [31:0] scaled;
    logic [7:0]  c;

    assign c  = i_item.char_in;
    assign dv = digit_value(c);

    always_comb begin
        s = i_state;
        if (i_item.token_start) begin
            s.phase       = PH_SKIP;
            s.radix_code  = RC_DEC;
            s.accumulator = 32'd0;
            s.negative    = 1'b0;
            s.have_digit  = 1'b0;
        end

        o_state     = s;
        o_res_valid = 1'b0;
        o_res       = '0;
        take        = 1'b0;

        unique case (s.phase)
            PH_SKIP: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_VT) begin
                    o_state = s;
                end else if (c == CH_MINUS) begin
                    o_state.negative = 1'b1;
                    o_state.phase    = PH_SIGN;
                end else if (c == CH_ZERO) begin
                    o_state.accumulator = 32'd0;
                    o_state.have_digit  = 1'b1;
                    o_state.phase       = PH_ZERO;
                end else begin
                    take = 1'b1;
                end
            end
            PH_SIGN: begin
                if (c == CH_ZERO) begin
                    o_state.accumulator = 32'd0;
                    o_state.have_digit  = 1'b1;
                    o_state.phase       = PH_ZERO;
                end else begin
                    take = 1'b1;
                end
            end
            PH_ZERO: begin
                if (c == CH_LC_X || c == CH_LC_O || c == CH_LC_B) begin
                    o_state.radix_code  = (c == CH_LC_X) ? RC_HEX :
                                          (c == CH_LC_O) ? RC_OCT : RC_BIN;
                    o_state.accumulator = 32'd0;
                    o_state.have_digit  = 1'b0;
                    o_state.phase       = PH_DIGIT;
                end else begin
                    take = 1'b1;
                end
            end
            PH_DIGIT: begin
                take = 1'b1;
            end
            default: begin
                o_state.phase = PH_IDLE;
            end
        endcase

        // Multiply by the radix as shifts; decimal is 8x plus 2x.
        case (s.radix_code)
            RC_HEX:  scaled = {s.accumulator[27:0], 4'd0};
            RC_OCT:  scaled = {s.accumulator[28:0], 3'd0};
            RC_BIN:  scaled = {s.accumulator[30:0], 1'b0};
            default: scaled = {s.accumulator[28:0], 3'd0} + {s.accumulator[30:0], 1'b0};
        endcase

        if (take) begin
            if (dv < {1'b0, radix_value(s.radix_code)}) begin
                o_state.accumulator = scaled + {26'd0, dv};
                o_state.have_digit  = 1'b1;
                o_state.phase       = PH_DIGIT;
            end else begin
                o_res_valid = 1'b1;
                o_res.ok    = s.have_digit;
                if (s.have_digit) begin
                    o_res.value = s.negative ? (32'd0 - s.accumulator) : s.accumulator;
                end
                o_state.phase = PH_IDLE;
            end
        end
    end

endmodule
